>>> rtl/core/tcfpq_pkg.sv
package tcfpq_pkg;

  // Default sizes of the slot table and its fields.
  localparam int SLOTS_DEF    = 16;
  localparam int ID_BITS_DEF  = 16;
  localparam int SEQ_BITS_DEF = 32;

  // Fixed widths of the stream fields.
  localparam int ID_W     = 16;
  localparam int SEQ_W    = 32;
  localparam int OCC_W    = 5;
  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 56;

  // Request kinds carried on the slave-side tuser.
  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_REMOVE = 1'b1
  } op_t;

  // Result status carried on the master-side tuser.
  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

endpackage

>>> rtl/core/tcfpq_ram.sv
module tcfpq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/core/two_class_fifo_priority_queue.sv
// An accepted request passes through the accept, a read of every slot in turn, a compare of
// each slot's entry behind its read, the exit from the scan, and the commit that issues the
// result. A new request is taken only once the last one has committed (s_tready while idle).
// The commit waits while an earlier result is still held on the result stream.
// Reset (rst, synchronous, active high) empties the table, clears the arrival counter and the
// occupancy, and drops any pending result; the entry RAM itself is not cleared.
module two_class_fifo_priority_queue
  import tcfpq_pkg::*;
#(
  parameter int SLOTS    = SLOTS_DEF,
  parameter int ID_BITS  = ID_BITS_DEF,
  parameter int SEQ_BITS = SEQ_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  // Request stream.
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,   // [15:0] item_id, [16] urgent, rest zero
  input  logic                  s_tuser,   // [0] operation
  // Result stream.
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata,   // [15:0] served_id, [16] served_urgent,
                                           // [48:17] served_sequence, [53:49] occupancy
  output logic [1:0]            m_tuser    // [1:0] status
);

  localparam int AW = $clog2(SLOTS);
  localparam int CW = $clog2(SLOTS + 1);
  localparam int EW = ID_BITS + 1 + SEQ_BITS;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_COMMIT
  } state_t;

  state_t state;

  // Request held for the length of the scan.
  op_t                 req_op;
  logic [ID_BITS-1:0]  req_id;
  logic                req_urgent;

  // Table state. The valid bits live in flops so that reset empties the table at once.
  logic [SLOTS-1:0]    valid;
  logic [SEQ_BITS-1:0] arrival;
  logic [CW-1:0]       held;

  // Scan sequencer: idx issues RAM reads, cmp_* is the compare stage behind them.
  logic [AW:0]         idx;
  logic                cmp_go;
  logic [AW-1:0]       cmp_idx;

  // Best slot found so far: the lowest free slot on an insert, the winning entry on a remove.
  logic                have_best;
  logic [AW-1:0]       best_idx;
  logic [ID_BITS-1:0]  best_id;
  logic                best_urgent;
  logic [SEQ_BITS-1:0] best_seq;

  // Entry RAM, laid out {sequence, urgent, id}.
  logic                ram_we;
  logic [EW-1:0]       ram_wdata;
  logic [EW-1:0]       ram_rdata;
  logic [ID_BITS-1:0]  rd_id;
  logic                rd_urgent;
  logic [SEQ_BITS-1:0] rd_seq;
  logic                cand_wins;
  logic                out_free;

  // Width adapters between the fixed stream fields and the parameterized storage.
  logic [ID_BITS+ID_W-1:0]   id_in_ext;
  logic [ID_BITS+ID_W-1:0]   id_out_ext;
  logic [SEQ_BITS+SEQ_W-1:0] seq_out_ext;
  logic [CW+OCC_W-1:0]       occ_ext;
  logic [CW-1:0]             held_next;
  logic [OUT_DATA_W-1:0]     out_data;

  tcfpq_ram #(
    .WIDTH (EW),
    .DEPTH (SLOTS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (best_idx),
    .wdata (ram_wdata),
    .raddr (idx[AW-1:0]),
    .rdata (ram_rdata)
  );

  assign rd_id     = ram_rdata[ID_BITS-1:0];
  assign rd_urgent = ram_rdata[ID_BITS];
  assign rd_seq    = ram_rdata[EW-1:ID_BITS+1];

  // Urgent beats normal; inside a class the smaller arrival stamp wins. On a tie the
  // earlier slot stays, since the scan runs upward.
  always_comb begin
    if (rd_urgent != best_urgent) begin
      cand_wins = rd_urgent;
    end else begin
      cand_wins = rd_seq < best_seq;
    end
  end

  assign out_free  = !m_tvalid || m_tready;
  assign s_tready  = (state == S_IDLE);
  assign ram_we    = (state == S_COMMIT) && out_free && (req_op == OP_INSERT) && have_best;
  assign ram_wdata = {arrival, req_urgent, req_id};

  assign id_in_ext   = {{ID_BITS{1'b0}}, s_tdata[ID_W-1:0]};
  assign id_out_ext  = {{ID_W{1'b0}}, best_id};
  assign seq_out_ext = {{SEQ_W{1'b0}}, best_seq};

  // Occupancy after the request, shown on the result.
  always_comb begin
    held_next = held;
    if (have_best) begin
      if (req_op == OP_INSERT) begin
        held_next = held + CW'(1);
      end else begin
        held_next = held - CW'(1);
      end
    end
  end

  assign occ_ext = {{OCC_W{1'b0}}, held_next};

  // Result word. The served fields are filled only by a remove that found an entry.
  always_comb begin
    out_data        = '0;
    out_data[53:49] = occ_ext[OCC_W-1:0];
    if (req_op == OP_REMOVE && have_best) begin
      out_data[15:0]  = id_out_ext[ID_W-1:0];
      out_data[16]    = best_urgent;
      out_data[48:17] = seq_out_ext[SEQ_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      valid     <= '0;
      arrival   <= '0;
      held      <= '0;
      m_tvalid  <= 1'b0;
      cmp_go    <= 1'b0;
      have_best <= 1'b0;
      idx       <= '0;
    end else begin
      if (m_tvalid && m_tready && state != S_COMMIT) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            req_op     <= op_t'(s_tuser);
            req_id     <= id_in_ext[ID_BITS-1:0];
            req_urgent <= s_tdata[ID_W];
            idx        <= '0;
            cmp_go     <= 1'b0;
            have_best  <= 1'b0;
            state      <= S_SCAN;
          end
        end
        S_SCAN: begin
          // Read stage.
          if (idx != (AW+1)'(SLOTS)) begin
            cmp_go  <= 1'b1;
            cmp_idx <= idx[AW-1:0];
            idx     <= idx + (AW+1)'(1);
          end else begin
            cmp_go <= 1'b0;
          end
          // Compare stage, fed by the read issued in the previous cycle.
          if (cmp_go) begin
            if (req_op == OP_INSERT) begin
              if (!valid[cmp_idx] && !have_best) begin
                have_best <= 1'b1;
                best_idx  <= cmp_idx;
              end
            end else begin
              if (valid[cmp_idx] && (!have_best || cand_wins)) begin
                have_best   <= 1'b1;
                best_idx    <= cmp_idx;
                best_id     <= rd_id;
                best_urgent <= rd_urgent;
                best_seq    <= rd_seq;
              end
            end
          end
          if (idx == (AW+1)'(SLOTS) && !cmp_go) begin
            state <= S_COMMIT;
          end
        end
        S_COMMIT: begin
          // The result register is free or empties at this edge, so it takes the new result.
          if (out_free) begin
            m_tvalid <= 1'b1;
            held     <= held_next;
            m_tdata  <= out_data;
            if (req_op == OP_INSERT) begin
              if (have_best) begin
                valid[best_idx] <= 1'b1;
                arrival         <= arrival + SEQ_BITS'(1);
                m_tuser         <= ST_DONE;
              end else begin
                m_tuser <= ST_FULL;
              end
            end else begin
              if (have_best) begin
                valid[best_idx] <= 1'b0;
                m_tuser         <= ST_DONE;
              end else begin
                m_tuser <= ST_EMPTY;
              end
            end
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

>>> tb/two_class_fifo_priority_queue_test.sv
module two_class_fifo_priority_queue_test;
  timeunit 1ns;
  timeprecision 1ps;

  import tcfpq_pkg::*;

  // Table size of the block under test; the shadow table below mirrors it.
  localparam int SLOT_COUNT = SLOTS_DEF;
  // Cycle budget for the whole run.
  localparam int CYCLE_LIMIT = 500000;
  // Cycles allowed for stray results once nothing more is expected.
  localparam int DRAIN_CYCLES = 2 * (SLOT_COUNT + 3);
  // Window of cycles in which neither side idles.
  localparam int CALM_FROM = 20000;
  localparam int CALM_TO   = 32000;
  localparam int BLOCK_LEN  = 50;
  localparam int BLOCK_RUNS = 39;

  // One request as the driver sees it, before packing onto the stream.
  typedef struct {
    op_t             op;
    logic [ID_W-1:0] id;
    logic            urgent;
  } request_t;

  // One result, unpacked field by field from the master-side stream.
  typedef struct {
    status_t          status;
    logic [ID_W-1:0]  id;
    logic             urgent;
    logic [SEQ_W-1:0] seq;
    logic [OCC_W-1:0] occ;
  } result_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata = '0;   // [15:0] item_id, [16] urgent, rest zero
  logic                  s_tuser = 1'b0; // [0] operation
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;        // [15:0] served_id, [16] served_urgent,
                                         // [48:17] served_sequence, [53:49] occupancy
  logic [1:0]            m_tuser;        // [1:0] status

  two_class_fifo_priority_queue uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  // Shadow copy of the slot table, the arrival counter and the occupancy.
  logic             shadow_held [SLOT_COUNT];
  logic [ID_W-1:0]  shadow_id   [SLOT_COUNT];
  logic             shadow_urg  [SLOT_COUNT];
  logic [SEQ_W-1:0] shadow_seq  [SLOT_COUNT];
  logic [SEQ_W-1:0] arrival_stamp = '0;
  int               held_total = 0;

  request_t pending_requests[$];
  result_t  awaited_results[$];

  logic req_taken = 1'b0;
  int   cycles = 0;
  int   bad_results = 0;
  int   inserts_seen = 0;
  int   removes_seen = 0;
  int   full_rejects = 0;
  int   empty_removes = 0;
  int   urgent_served = 0;
  int   peak_held = 0;

  initial begin
    for (int i = 0; i < SLOT_COUNT; i++) begin
      shadow_held[i] = 1'b0;
    end
  end

  initial begin
    forever #5 clk = ~clk;
  end

  // Applies one request to the shadow table and returns the result the block
  // must produce for it. An insert takes the lowest free slot; a remove serves
  // urgent entries first and, within a class, the smallest arrival stamp, with
  // the lowest slot index breaking a tie.
  function automatic result_t serve_request(request_t req);
    result_t res;
    int      pick;
    res.status = ST_DONE;
    res.id     = '0;
    res.urgent = 1'b0;
    res.seq    = '0;
    pick       = -1;
    if (req.op == OP_INSERT) begin
      inserts_seen++;
      for (int i = 0; i < SLOT_COUNT; i++) begin
        if (pick < 0 && !shadow_held[i]) begin
          pick = i;
        end
      end
      if (pick < 0) begin
        res.status = ST_FULL;
        full_rejects++;
      end else begin
        shadow_held[pick] = 1'b1;
        shadow_id[pick]   = req.id;
        shadow_urg[pick]  = req.urgent;
        shadow_seq[pick]  = arrival_stamp;
        arrival_stamp     = arrival_stamp + 1'b1;
        held_total++;
        if (held_total > peak_held) begin
          peak_held = held_total;
        end
      end
    end else begin
      removes_seen++;
      for (int i = 0; i < SLOT_COUNT; i++) begin
        if (shadow_held[i]) begin
          if (pick < 0) begin
            pick = i;
          end else if (shadow_urg[i] != shadow_urg[pick]) begin
            if (shadow_urg[i]) begin
              pick = i;
            end
          end else if (shadow_seq[i] < shadow_seq[pick]) begin
            pick = i;
          end
        end
      end
      if (pick < 0) begin
        res.status = ST_EMPTY;
        empty_removes++;
      end else begin
        res.id            = shadow_id[pick];
        res.urgent        = shadow_urg[pick];
        res.seq           = shadow_seq[pick];
        shadow_held[pick] = 1'b0;
        held_total--;
        if (shadow_urg[pick]) begin
          urgent_served++;
        end
      end
    end
    res.occ = held_total[OCC_W-1:0];
    return res;
  endfunction

  // Random idling for both sides, switched off inside the calm window.
  function automatic bit take_break();
    if (cycles >= CALM_FROM && cycles < CALM_TO) begin
      return 1'b0;
    end
    return $urandom_range(99) < 12;
  endfunction

  task automatic queue_request(op_t op, logic [ID_W-1:0] id, logic urgent);
    request_t req;
    req.op     = op;
    req.id     = id;
    req.urgent = urgent;
    pending_requests.push_back(req);
  endtask

  // Cycle counter and watchdog.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d requests still unsent, %0d results missing",
               cycles, pending_requests.size(), awaited_results.size());
      $display("tb: failure");
      $finish;
    end
  end

  // Request driver. A new request is presented at the falling edge once the
  // previous one has been taken, or the bus was idle.
  always @(negedge clk) begin : driver
    request_t nxt;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || req_taken) begin
      if (pending_requests.size() != 0 && !take_break()) begin
        nxt = pending_requests.pop_front();
        s_tvalid <= 1'b1;
        s_tuser  <= nxt.op;
        s_tdata  <= IN_DATA_W'({nxt.urgent, nxt.id});
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Result-side backpressure.
  always @(negedge clk) begin
    m_tready <= rst ? 1'b0 : !take_break();
  end

  // Monitor. Accepted requests feed the shadow table; accepted results are
  // checked against the oldest expectation.
  always @(posedge clk) begin : monitor
    request_t req;
    result_t  got;
    result_t  want;
    req_taken <= !rst && s_tvalid && s_tready;
    if (!rst && m_tvalid && m_tready) begin
      got.status = status_t'(m_tuser);
      got.id     = m_tdata[15:0];
      got.urgent = m_tdata[16];
      got.seq    = m_tdata[48:17];
      got.occ    = m_tdata[53:49];
      if (awaited_results.size() == 0) begin
        bad_results++;
        if (bad_results <= 10) begin
          $display("cycle %0d: result with nothing outstanding: status %0d id %h seq %0d",
                   cycles, got.status, got.id, got.seq);
        end
      end else begin
        want = awaited_results.pop_front();
        if (got.status != want.status || got.id != want.id || got.urgent != want.urgent ||
            got.seq != want.seq || got.occ != want.occ) begin
          bad_results++;
          if (bad_results <= 10) begin
            $display("cycle %0d: expected status %0d id %h urgent %0d seq %0d occ %0d",
                     cycles, want.status, want.id, want.urgent, want.seq, want.occ);
            $display("cycle %0d:      got status %0d id %h urgent %0d seq %0d occ %0d",
                     cycles, got.status, got.id, got.urgent, got.seq, got.occ);
          end
        end
      end
    end
    if (!rst && s_tvalid && s_tready) begin
      req.op     = op_t'(s_tuser);
      req.id     = s_tdata[ID_W-1:0];
      req.urgent = s_tdata[ID_W];
      awaited_results.push_back(serve_request(req));
    end
  end

  initial begin : stimulus
    int insert_pct;
    int urgent_pct;
    int id_mode;
    logic [ID_W-1:0] id;

    // Directed part: a remove on the empty table, a fill to capacity with
    // extreme and patterned ids in both classes, two inserts that must be
    // rejected as full, then a handful of removes that show the class order
    // and the arrival order within a class.
    queue_request(OP_REMOVE, 16'h0000, 1'b0);
    queue_request(OP_INSERT, 16'h0000, 1'b0);
    queue_request(OP_INSERT, 16'hFFFF, 1'b1);
    queue_request(OP_INSERT, 16'hAAAA, 1'b0);
    queue_request(OP_INSERT, 16'h5555, 1'b1);
    for (int i = 4; i < SLOT_COUNT; i++) begin
      queue_request(OP_INSERT, ID_W'(i * 16'h1111), i[0]);
    end
    queue_request(OP_INSERT, 16'h1234, 1'b1);
    queue_request(OP_INSERT, 16'hFFFF, 1'b0);
    for (int i = 0; i < 5; i++) begin
      queue_request(OP_REMOVE, 16'hFFFF, 1'b1);
    end

    // Random part in blocks. Each block has its own mix of inserts and removes,
    // so the table drifts between empty and full and both rejection cases
    // recur. Ids lean on the extremes now and then; the class mix also varies.
    for (int b = 0; b < BLOCK_RUNS; b++) begin
      case ($urandom_range(3))
        0: begin
          insert_pct = 15;
        end
        1: begin
          insert_pct = 50;
        end
        2: begin
          insert_pct = 85;
        end
        default: begin
          insert_pct = 97;
        end
      endcase
      case ($urandom_range(2))
        0: begin
          urgent_pct = 10;
        end
        1: begin
          urgent_pct = 50;
        end
        default: begin
          urgent_pct = 90;
        end
      endcase
      for (int k = 0; k < BLOCK_LEN; k++) begin
        id_mode = $urandom_range(9);
        if (id_mode == 0) begin
          id = '0;
        end else if (id_mode == 1) begin
          id = '1;
        end else begin
          id = ID_W'($urandom);
        end
        queue_request(($urandom_range(99) < insert_pct) ? OP_INSERT : OP_REMOVE, id,
                      $urandom_range(99) < urgent_pct);
      end
    end

    // Single reset at the start of the run.
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (pending_requests.size() != 0 || s_tvalid || awaited_results.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("summary: %0d inserts (%0d refused on a full table), %0d removes (%0d on empty)",
             inserts_seen, full_rejects, removes_seen, empty_removes);
    $display("summary: %0d urgent entries served, peak occupancy %0d of %0d, %0d bad results",
             urgent_served, peak_held, SLOT_COUNT, bad_results);
    if (bad_results == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
